FILE: rtl/assert_macros.svh
// assert_macros.svh - assertion helper macros for the rescheduler checker.
// No dependencies; expects signals named clock and reset in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, masked while reset is high.
`define CHK_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Concurrent check that also runs through reset.
`define CHK_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: rtl/rsched_pkg.sv
// rsched_pkg.sv - shared constants, status codes and control structs of the
// priority order rescheduler. No dependencies.
`default_nettype none

package rsched_pkg;

   localparam int COUNT_W    = 16;  // collision count width
   localparam int ROBOT_IN_W = 3;   // colliding robot field width
   localparam int SLOT_OUT_W = 3;   // per-slot result field width
   localparam int OUT_SLOTS  = 8;   // slot fields on the result channel
   localparam int IN_ROBOTS  = 8;   // count fields on the request channel
   localparam int STATUS_W   = 2;
   localparam int CFG_W      = 4;   // robots_in_use width

   localparam logic [CFG_W-1:0] ROBOTS_RESET = 4'd8;

   // register index (paddr[2])
   localparam logic REG_ROBOTS = 1'b0;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_ADOPTED   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_ROBOT = 2'd2;

   typedef struct packed {
      logic restart;  // back to one-entry history
      logic start;    // rewind scan pointer
      logic run;      // scan in progress
      logic record;   // write candidate into ring
   } hist_ctrl_type;

   typedef struct packed {
      logic ready;    // entry 0 initialized
      logic hit;      // candidate found in history
      logic miss;     // last entry compared, no match
   } hist_stat_type;

endpackage

`default_nettype wire

FILE: rtl/rsched_hist.sv
// rsched_hist.sv - ring of tried orders with one-entry-per-cycle match scan.
// Depends on rsched_pkg.
`default_nettype none

module rsched_hist #(
   parameter int MAX_ROBOTS    = 8,
   parameter int HISTORY_DEPTH = 64
) (
   input  wire                                      clock,
   input  wire                                      reset,
   input  rsched_pkg::hist_ctrl_type                ctrl,
   input  wire [MAX_ROBOTS*$clog2(MAX_ROBOTS)-1:0]  cand,
   output rsched_pkg::hist_stat_type                stat
);
   import rsched_pkg::*;

   localparam int RW      = $clog2(MAX_ROBOTS);
   localparam int ORDER_W = MAX_ROBOTS * RW;
   localparam int AW      = $clog2(HISTORY_DEPTH);
   localparam int CW      = $clog2(HISTORY_DEPTH + 1);

   logic [ORDER_W-1:0] mem [HISTORY_DEPTH];

   logic [CW-1:0]      count_ff, count_in;
   logic [AW-1:0]      wslot_ff, wslot_in;
   logic               init_ff, init_in;
   logic [CW-1:0]      scan_ff, scan_in;
   logic               pend_ff, pend_in;
   logic               last_ff, last_in;
   logic [ORDER_W-1:0] rd_data_ff;
   logic [ORDER_W-1:0] identity;
   logic               issue;
   logic               match;

   always_comb begin
      for (int i = 0; i < MAX_ROBOTS; i++) begin
         identity[i*RW +: RW] = RW'(i);
      end
   end

   assign issue      = ctrl.run && (scan_ff != count_ff);
   assign match      = (rd_data_ff == cand);
   assign stat.ready = ~init_ff;
   assign stat.hit   = ctrl.run && pend_ff && match;
   assign stat.miss  = ctrl.run && pend_ff && last_ff && !match;

   always_comb begin
      count_in = count_ff;
      wslot_in = wslot_ff;
      init_in  = 1'b0;
      scan_in  = scan_ff;
      pend_in  = issue;
      last_in  = issue && (CW'(scan_ff + 1'b1) == count_ff);
      if (ctrl.start) begin
         scan_in = '0;
      end else if (issue) begin
         scan_in = CW'(scan_ff + 1'b1);
      end
      if (ctrl.record) begin
         wslot_in = (wslot_ff == AW'(HISTORY_DEPTH - 1)) ? '0 : AW'(wslot_ff + 1'b1);
         if (count_ff != CW'(HISTORY_DEPTH)) begin
            count_in = CW'(count_ff + 1'b1);
         end
      end
      if (ctrl.restart) begin
         count_in = CW'(1);
         wslot_in = AW'(1);
         init_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CW'(1);
         wslot_ff <= AW'(1);
         init_ff  <= 1'b1;
         scan_ff  <= '0;
         pend_ff  <= 1'b0;
         last_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         wslot_ff <= wslot_in;
         init_ff  <= init_in;
         scan_ff  <= scan_in;
         pend_ff  <= pend_in;
         last_ff  <= last_in;
      end
   end

   // single write port, single registered read port
   always_ff @(posedge clock) begin
      if (init_ff) begin
         mem[0] <= identity;
      end else if (ctrl.record) begin
         mem[wslot_ff] <= cand;
      end
      if (issue) begin
         rd_data_ff <= mem[scan_ff[AW-1:0]];
      end
   end

endmodule

`default_nettype wire

FILE: rtl/priority_order_rescheduler_core.sv
// priority_order_rescheduler_core.sv - top level of the priority order rescheduler.
// Depends on rsched_pkg and rsched_hist.
//
//  channel | ports                         | transfer when
//  --------+-------------------------------+-----------------------------
//  request | req_valid/req_ready, req_*    | req_valid & req_ready
//  result  | rsp_valid/rsp_ready, rsp_*    | rsp_valid & rsp_ready
//  config  | psel/penable/pwrite/paddr/... | psel & penable & pwrite
//
//  Per request: a search over up to n slots finds p, the colliding robot's slot;
//    then up to max(p,1) attempts each pick over slots 0..p-1 and scan the T stored
//    orders (T <= HISTORY_DEPTH) through the history memory read port, one entry per
//    cycle. A robot out of range goes straight to the result.
//  Reset: identity order, robots_in_use 8, history holds identity only; reset and a
//    robots_in_use write raise an init flag that writes entry 0 and holds ready low.
//  A finished result sits in the output register; the next request is taken
//    while it waits, and only the write of the following result stalls on rsp_ready.
`default_nettype none

module priority_order_rescheduler_core #(
   parameter int MAX_ROBOTS    = 8,
   parameter int HISTORY_DEPTH = 64
) (
   input  wire         clock,
   input  wire         reset,
   // request channel
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [2:0]  req_colliding_robot,
   input  wire  [15:0] req_collisions_0,
   input  wire  [15:0] req_collisions_1,
   input  wire  [15:0] req_collisions_2,
   input  wire  [15:0] req_collisions_3,
   input  wire  [15:0] req_collisions_4,
   input  wire  [15:0] req_collisions_5,
   input  wire  [15:0] req_collisions_6,
   input  wire  [15:0] req_collisions_7,
   // result channel
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [2:0]  rsp_first_replan_slot,
   output logic [2:0]  rsp_slot_0,
   output logic [2:0]  rsp_slot_1,
   output logic [2:0]  rsp_slot_2,
   output logic [2:0]  rsp_slot_3,
   output logic [2:0]  rsp_slot_4,
   output logic [2:0]  rsp_slot_5,
   output logic [2:0]  rsp_slot_6,
   output logic [2:0]  rsp_slot_7,
   // configuration port
   input  wire         psel,
   input  wire         penable,
   input  wire         pwrite,
   input  wire  [2:0]  paddr,
   input  wire  [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import rsched_pkg::*;

   localparam int RW      = $clog2(MAX_ROBOTS);   // robot / slot index width
   localparam int RW1     = RW + 1;
   localparam int ORDER_W = MAX_ROBOTS * RW;

   // sequencer states
   localparam logic [2:0] S_IDLE   = 3'd0;  // wait for request
   localparam logic [2:0] S_LOCATE = 3'd1;  // find slot p of colliding robot
   localparam logic [2:0] S_PICK   = 3'd2;  // max-count scan over slots 0..p-1
   localparam logic [2:0] S_SCAN   = 3'd3;  // compare candidate with history
   localparam logic [2:0] S_FINISH = 3'd4;  // hand result to output register

   localparam logic [4:0] MAX5 = 5'(MAX_ROBOTS);

   logic [2:0]         state_ff, state_in;
   logic [CFG_W-1:0]   robots_ff, robots_in;
   logic [RW-1:0]      order_ff [MAX_ROBOTS];
   logic [RW-1:0]      order_in [MAX_ROBOTS];
   logic [RW-1:0]      cand_ff [MAX_ROBOTS];
   logic [RW-1:0]      cand_in [MAX_ROBOTS];
   logic [COUNT_W-1:0] counts_ff [MAX_ROBOTS];
   logic [COUNT_W-1:0] counts_in [MAX_ROBOTS];
   logic [RW-1:0]      robot_ff, robot_in;
   logic [RW-1:0]      p_ff, p_in;
   logic [RW-1:0]      idx_ff, idx_in;
   logic [RW-1:0]      first_ff, first_in;
   logic [COUNT_W-1:0] best_ff, best_in;
   logic [RW-1:0]      best_robot_ff, best_robot_in;
   logic [RW-1:0]      attempt_ff, attempt_in;
   logic [STATUS_W-1:0] status_ff, status_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [2:0]         rsp_first_ff, rsp_first_in;
   logic [2:0]         rsp_slot_ff [OUT_SLOTS];
   logic [2:0]         rsp_slot_in [OUT_SLOTS];

   logic [COUNT_W-1:0] req_counts [IN_ROBOTS];
   logic [4:0]         n_robots;
   logic               req_accept;
   logic               cfg_write;
   logic               robot_ok;
   logic [ORDER_W-1:0] cand_vec;
   hist_ctrl_type      hist_ctrl;
   hist_stat_type      hist_stat;

   // low three bits of a slot or robot index, as the result fields carry them
   function automatic logic [2:0] low3(input logic [3:0] v);
      return v[2:0];
   endfunction

   assign req_counts[0] = req_collisions_0;
   assign req_counts[1] = req_collisions_1;
   assign req_counts[2] = req_collisions_2;
   assign req_counts[3] = req_collisions_3;
   assign req_counts[4] = req_collisions_4;
   assign req_counts[5] = req_collisions_5;
   assign req_counts[6] = req_collisions_6;
   assign req_counts[7] = req_collisions_7;

   // robots_in_use clamped to 1..MAX_ROBOTS
   always_comb begin
      if (robots_ff == '0) begin
         n_robots = 5'd1;
      end else if ({1'b0, robots_ff} > MAX5) begin
         n_robots = MAX5;
      end else begin
         n_robots = {1'b0, robots_ff};
      end
   end

   assign robot_ok   = ({2'b00, req_colliding_robot} < n_robots);
   assign req_ready  = (state_ff == S_IDLE) && hist_stat.ready;
   assign req_accept = req_valid && req_ready;

   // config: single register at index 0, low address bits ignored
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_ROBOTS);
   assign prdata    = (paddr[2] == REG_ROBOTS) ? 32'(robots_ff) : '0;

   always_comb begin
      for (int i = 0; i < MAX_ROBOTS; i++) begin
         cand_vec[i*RW +: RW] = cand_ff[i];
      end
   end

   rsched_hist #(
      .MAX_ROBOTS    (MAX_ROBOTS),
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_hist (
      .clock (clock),
      .reset (reset),
      .ctrl  (hist_ctrl),
      .cand  (cand_vec),
      .stat  (hist_stat)
   );

   always_comb begin
      logic [COUNT_W-1:0] pick_count;
      logic [RW1-1:0]     attempt_next;
      logic [RW1-1:0]     attempt_lim;

      state_in      = state_ff;
      robots_in     = robots_ff;
      order_in      = order_ff;
      cand_in       = cand_ff;
      counts_in     = counts_ff;
      robot_in      = robot_ff;
      p_in          = p_ff;
      idx_in        = idx_ff;
      first_in      = first_ff;
      best_in       = best_ff;
      best_robot_in = best_robot_ff;
      attempt_in    = attempt_ff;
      status_in     = status_ff;
      hist_ctrl     = '0;

      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_first_in  = rsp_first_ff;
      rsp_slot_in   = rsp_slot_ff;

      pick_count   = counts_ff[cand_ff[idx_ff]];
      attempt_next = RW1'({1'b0, attempt_ff} + 1'b1);
      attempt_lim  = (p_ff == '0) ? RW1'(1) : {1'b0, p_ff};

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               robot_in = RW'(req_colliding_robot);
               cand_in  = order_ff;
               idx_in   = '0;
               first_in = '0;
               for (int i = 0; i < MAX_ROBOTS; i++) begin
                  counts_in[i] = (i < IN_ROBOTS) ? req_counts[i % IN_ROBOTS] : '0;
               end
               if (robot_ok) begin
                  state_in = S_LOCATE;
               end else begin
                  status_in = ST_BAD_ROBOT;
                  state_in  = S_FINISH;
               end
            end
         end

         S_LOCATE: begin
            // robot is below n, so it sits in one of the first n slots
            if (cand_ff[idx_ff] == robot_ff) begin
               p_in          = idx_ff;
               idx_in        = '0;
               first_in      = '0;
               best_in       = '0;
               best_robot_in = robot_ff;
               attempt_in    = '0;
               state_in      = S_PICK;
            end else begin
               idx_in = RW'(idx_ff + 1'b1);
            end
         end

         S_PICK: begin
            if (idx_ff == p_ff) begin
               // swap picked slot with the colliding robot's slot
               cand_in[first_ff] = robot_ff;
               cand_in[p_ff]     = best_robot_ff;
               hist_ctrl.start   = 1'b1;
               state_in          = S_SCAN;
            end else begin
               // slot 0 always seeds the pick; later slots need a strictly larger count
               if ((idx_ff == '0) || (pick_count > best_ff)) begin
                  best_in       = pick_count;
                  first_in      = idx_ff;
                  best_robot_in = cand_ff[idx_ff];
               end
               idx_in = RW'(idx_ff + 1'b1);
            end
         end

         S_SCAN: begin
            hist_ctrl.run = 1'b1;
            if (hist_stat.hit) begin
               // already tried: undo the swap and drop that robot from the pick
               cand_in[first_ff]        = best_robot_ff;
               cand_in[p_ff]            = robot_ff;
               counts_in[best_robot_ff] = '0;
               if (attempt_next == attempt_lim) begin
                  status_in = ST_EXHAUSTED;
                  state_in  = S_FINISH;
               end else begin
                  attempt_in = attempt_next[RW-1:0];
                  idx_in     = '0;
                  best_in    = '0;
                  state_in   = S_PICK;
               end
            end else if (hist_stat.miss) begin
               order_in         = cand_ff;
               hist_ctrl.record = 1'b1;
               status_in        = ST_ADOPTED;
               state_in         = S_FINISH;
            end
         end

         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_first_in  = low3(4'(first_ff));
               for (int i = 0; i < OUT_SLOTS; i++) begin
                  rsp_slot_in[i] = (i < MAX_ROBOTS) ?
                                   low3(4'(order_ff[i % MAX_ROBOTS])) : 3'd0;
               end
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // robots_in_use write: identity order, history back to identity only
      if (cfg_write) begin
         robots_in = pwdata[CFG_W-1:0];
         for (int i = 0; i < MAX_ROBOTS; i++) begin
            order_in[i] = RW'(i);
         end
         hist_ctrl.restart = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         robots_ff    <= ROBOTS_RESET;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_ROBOTS; i++) begin
            order_ff[i] <= RW'(i);
         end
      end else begin
         state_ff     <= state_in;
         robots_ff    <= robots_in;
         rsp_valid_ff <= rsp_valid_in;
         order_ff     <= order_in;
      end
   end

   // datapath registers, no reset needed
   always_ff @(posedge clock) begin
      cand_ff       <= cand_in;
      counts_ff     <= counts_in;
      robot_ff      <= robot_in;
      p_ff          <= p_in;
      idx_ff        <= idx_in;
      first_ff      <= first_in;
      best_ff       <= best_in;
      best_robot_ff <= best_robot_in;
      attempt_ff    <= attempt_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_first_replan_slot = rsp_first_ff;
   assign rsp_slot_0            = rsp_slot_ff[0];
   assign rsp_slot_1            = rsp_slot_ff[1];
   assign rsp_slot_2            = rsp_slot_ff[2];
   assign rsp_slot_3            = rsp_slot_ff[3];
   assign rsp_slot_4            = rsp_slot_ff[4];
   assign rsp_slot_5            = rsp_slot_ff[5];
   assign rsp_slot_6            = rsp_slot_ff[6];
   assign rsp_slot_7            = rsp_slot_ff[7];

endmodule

`default_nettype wire

FILE: rtl/rsched_checker.sv
// rsched_checker.sv - port-level checks of the rescheduler top, bound to it below.
// Depends on rsched_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module rsched_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_valid,
   input wire        req_ready,
   input wire        rsp_valid,
   input wire        rsp_ready,
   input wire [1:0]  rsp_status,
   input wire [2:0]  rsp_first_replan_slot,
   input wire [2:0]  rsp_slot_0
);
   import rsched_pkg::*;

   logic stall;
   logic bad_rsp;

   assign stall   = rsp_valid && !rsp_ready;
   assign bad_rsp = rsp_valid && (rsp_status == ST_BAD_ROBOT);

   // one request in work at a time
   `CHK_ASSERT(a_one_in_work, req_valid && req_ready |=> !req_ready, "request taken while busy")

   // rejected robot reports slot 0
   `CHK_ASSERT(a_bad_slot, bad_rsp |-> rsp_first_replan_slot == 3'd0, "bad robot slot")

   // stalled result stays offered and holds
   `CHK_ASSERT(a_valid_hold, stall |=> rsp_valid, "stalled result dropped")
   `CHK_ASSERT(a_hold, stall |=> $stable(rsp_status) && $stable(rsp_slot_0), "result moved")

   // no result straight out of reset
   `CHK_ASSERT_RST(a_reset_quiet, reset |=> !rsp_valid, "result valid after reset")

endmodule

bind priority_order_rescheduler_core rsched_checker u_rsched_checker (.*);

`default_nettype wire

FILE: test/tb_priority_order_rescheduler_core.sv
`timescale 1ns / 100ps
// tb_priority_order_rescheduler_core.sv - self-checking bench for the priority order
// rescheduler: directed and random requests, in-bench prediction, APB setting writes.
// Depends on rsched_pkg and priority_order_rescheduler_core.

module tb_priority_order_rescheduler_core;
   import rsched_pkg::*;

   localparam int NUM_ROBOTS    = 8;          // MAX_ROBOTS of the instance
   localparam int RING_DEPTH    = 64;         // HISTORY_DEPTH of the instance
   localparam int MAX_GAP       = 16;         // per-transfer idle draw, either side
   localparam int LONG_HOLD     = 2000;       // receiver hold-off, cycles
   localparam int SETTLE_CYCLES = 600;        // beyond one worst-case request
   // worst-case request plus both idle draws, ~800 requests, taken 5x over
   localparam int CYCLE_LIMIT   = 2_500_000;
   localparam logic [2:0] ADDR_ROBOTS = {REG_ROBOTS, 2'b00};

   typedef logic [NUM_ROBOTS-1:0][SLOT_OUT_W-1:0] order_type;

   typedef struct packed {
      logic [ROBOT_IN_W-1:0]              robot;
      logic [IN_ROBOTS-1:0][COUNT_W-1:0]  counts;
   } resched_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]                   status;
      logic [SLOT_OUT_W-1:0]                 first_slot;
      logic [OUT_SLOTS-1:0][SLOT_OUT_W-1:0]  slots;
   } resched_rsp_type;

   // ---------------------------------------------------------------
   // DUT signals
   // ---------------------------------------------------------------
   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [2:0]  req_colliding_robot;
   logic [15:0] req_collisions_0, req_collisions_1, req_collisions_2, req_collisions_3;
   logic [15:0] req_collisions_4, req_collisions_5, req_collisions_6, req_collisions_7;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_status;
   logic [2:0]  rsp_first_replan_slot;
   logic [2:0]  rsp_slot_0, rsp_slot_1, rsp_slot_2, rsp_slot_3;
   logic [2:0]  rsp_slot_4, rsp_slot_5, rsp_slot_6, rsp_slot_7;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   priority_order_rescheduler_core #(
      .MAX_ROBOTS    (NUM_ROBOTS),
      .HISTORY_DEPTH (RING_DEPTH)
   ) u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_colliding_robot   (req_colliding_robot),
      .req_collisions_0      (req_collisions_0),
      .req_collisions_1      (req_collisions_1),
      .req_collisions_2      (req_collisions_2),
      .req_collisions_3      (req_collisions_3),
      .req_collisions_4      (req_collisions_4),
      .req_collisions_5      (req_collisions_5),
      .req_collisions_6      (req_collisions_6),
      .req_collisions_7      (req_collisions_7),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_status            (rsp_status),
      .rsp_first_replan_slot (rsp_first_replan_slot),
      .rsp_slot_0            (rsp_slot_0),
      .rsp_slot_1            (rsp_slot_1),
      .rsp_slot_2            (rsp_slot_2),
      .rsp_slot_3            (rsp_slot_3),
      .rsp_slot_4            (rsp_slot_4),
      .rsp_slot_5            (rsp_slot_5),
      .rsp_slot_6            (rsp_slot_6),
      .rsp_slot_7            (rsp_slot_7),
      .psel                  (psel),
      .penable               (penable),
      .pwrite                (pwrite),
      .paddr                 (paddr),
      .pwdata                (pwdata),
      .prdata                (prdata),
      .pready                (pready)
   );

   // ---------------------------------------------------------------
   // Bench state
   // ---------------------------------------------------------------
   resched_rsp_type expected_results[$];   // one entry per accepted request
   int  error_count = 0;
   int  cycle_count = 0;
   bit  idle_on     = 1'b1;             // 0: both sides run back to back
   int  ready_wait  = 0;                // receiver idle left before next result
   int  hold_request = 0;               // long hold-off asked of the receiver

   // Shadow of the scheduler: setting, current order and the ring of tried orders.
   logic [CFG_W-1:0] robot_setting;
   order_type        sched_order;
   order_type        tried_ring [RING_DEPTH];
   int               tried_total;
   int               tried_next;

   // ---------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------
   // Identity order, ring holds only that order.
   function automatic void restart_schedule();
      for (int i = 0; i < NUM_ROBOTS; i++) sched_order[i] = SLOT_OUT_W'(i);
      for (int e = 0; e < RING_DEPTH; e++) tried_ring[e] = '0;
      tried_ring[0] = sched_order;
      tried_total   = 1;
      tried_next    = 1 % RING_DEPTH;
   endfunction

   // Setting of 0 acts as 1, anything above the instance size as the size.
   function automatic int active_robots();
      int n;
      n = int'(robot_setting);
      if (n < 1) n = 1;
      if (n > NUM_ROBOTS) n = NUM_ROBOTS;
      return n;
   endfunction

   // Only the first n slots take part in the history compare.
   function automatic bit order_tried(input order_type cand, input int n);
      bit same;
      for (int e = 0; e < tried_total && e < RING_DEPTH; e++) begin
         same = 1'b1;
         for (int i = 0; i < n; i++)
            if (cand[i] != tried_ring[e][i]) same = 1'b0;
         if (same) return 1'b1;
      end
      return 1'b0;
   endfunction

   // Works out the result of one request and advances the shadow state.
   function automatic resched_rsp_type predict_reschedule(input resched_req_type rq);
      int               n;
      int               p;
      int               attempts;
      int               first_slot;
      logic [COUNT_W:0] best;
      logic [COUNT_W-1:0] work [NUM_ROBOTS];
      order_type        cand;
      bit               found;
      logic [2:0]       t;
      resched_rsp_type  rs;

      n             = active_robots();
      rs.status     = ST_BAD_ROBOT;
      rs.first_slot = '0;
      rs.slots      = sched_order;
      if (int'(rq.robot) >= n) return rs;     // robot out of range: nothing changes

      for (int i = 0; i < NUM_ROBOTS; i++) work[i] = rq.counts[i];

      p = 0;
      for (int i = 0; i < n; i++)
         if (sched_order[i] == rq.robot) begin
            p = i;
            break;
         end

      cand       = sched_order;
      attempts   = (p == 0) ? 1 : p;     // robot in slot 0 still gets one self-swap
      found      = 1'b0;
      first_slot = 0;
      for (int a = 0; a < attempts && !found; a++) begin
         best       = '0;
         first_slot = 0;
         // strict compare: ties keep the lowest slot, all-zero keeps slot 0
         for (int i = 0; i < p; i++)
            if ({1'b0, work[cand[i]]} > best) begin
               best       = {1'b0, work[cand[i]]};
               first_slot = i;
            end
         t = cand[first_slot]; cand[first_slot] = cand[p]; cand[p] = t;
         if (!order_tried(cand, n)) begin
            found = 1'b1;
         end else begin
            // undo, and drop the robot in the picked slot from the next search
            t = cand[first_slot]; cand[first_slot] = cand[p]; cand[p] = t;
            work[cand[first_slot]] = '0;
         end
      end

      rs.first_slot = SLOT_OUT_W'(first_slot);
      if (!found) begin
         rs.status = ST_EXHAUSTED;
         return rs;
      end

      sched_order            = cand;
      tried_ring[tried_next] = cand;       // oldest entry goes once the ring is full
      tried_next             = (tried_next + 1) % RING_DEPTH;
      if (tried_total < RING_DEPTH) tried_total++;
      rs.status = ST_ADOPTED;
      rs.slots  = sched_order;
      return rs;
   endfunction

   // ---------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------
   function automatic int draw_gap();
      return idle_on ? int'($urandom_range(0, MAX_GAP)) : 0;
   endfunction

   function automatic resched_req_type uniform_request(input int robot, input int value);
      resched_req_type rq;
      rq.robot = ROBOT_IN_W'(robot);
      for (int i = 0; i < IN_ROBOTS; i++) rq.counts[i] = COUNT_W'(value);
      return rq;
   endfunction

   // Mostly in-range robots; count shapes chosen to give ties, single
   // candidates, full-range values and the extremes.
   function automatic resched_req_type random_request(input int n);
      resched_req_type rq;
      int              shape;
      int              hot;
      shape = $urandom_range(0, 3);
      hot   = $urandom_range(0, IN_ROBOTS - 1);
      if ($urandom_range(0, 9) == 0) rq.robot = ROBOT_IN_W'($urandom_range(0, 7));
      else                           rq.robot = ROBOT_IN_W'($urandom_range(0, n - 1));
      for (int i = 0; i < IN_ROBOTS; i++) begin
         case (shape)
            0: rq.counts[i] = COUNT_W'($urandom_range(0, 3));
            1: rq.counts[i] = COUNT_W'($urandom);
            2: rq.counts[i] = (i == hot) ? COUNT_W'($urandom_range(1, 65535)) : '0;
            default: begin
               case ($urandom_range(0, 3))
                  0: rq.counts[i] = '0;
                  1: rq.counts[i] = '1;
                  2: rq.counts[i] = COUNT_W'($urandom_range(0, 15));
                  default: rq.counts[i] = COUNT_W'($urandom);
               endcase
            end
         endcase
      end
      return rq;
   endfunction

   // One request transfer; the expectation is queued at the accepting edge.
   task automatic send_request(input resched_req_type rq);
      int              gap;
      resched_rsp_type predicted;
      gap = draw_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_colliding_robot <= rq.robot;
      req_collisions_0    <= rq.counts[0];
      req_collisions_1    <= rq.counts[1];
      req_collisions_2    <= rq.counts[2];
      req_collisions_3    <= rq.counts[3];
      req_collisions_4    <= rq.counts[4];
      req_collisions_5    <= rq.counts[5];
      req_collisions_6    <= rq.counts[6];
      req_collisions_7    <= rq.counts[7];
      req_valid           <= 1'b1;
      do @(posedge clock); while (!req_ready);
      predicted        = predict_reschedule(rq);
      expected_results = {expected_results, predicted};
   endtask

   // Sender goes quiet until every expected result has come back.
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   // APB write of robots_in_use, only with the block idle. Upper data bits are noise.
   task automatic write_robots(input int setting);
      logic [31:0] value;
      value = {28'($urandom), 4'(setting)};
      wait_drained();
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_ROBOTS;
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      robot_setting = value[CFG_W-1:0];
      restart_schedule();
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      pwdata  <= 32'($urandom);
   endtask

   task automatic run_random_phase(input int setting, input int amount, input bit idle);
      idle_on = idle;
      write_robots(setting);
      repeat (amount) send_request(random_request(active_robots()));
   endtask

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------
   // Slot-0 robot, ties, zero and full counts, exhausted history, bad robot,
   // and the settings 0, 1, 2, 8 and 15.
   task automatic test_directed();
      resched_req_type rq;
      idle_on = 1'b1;
      send_request(uniform_request(0, 0));       // slot 0, identity already tried
      send_request(uniform_request(7, 0));       // no count: swap with slot 0
      send_request(uniform_request(7, 0));       // now in slot 0, order already tried
      send_request(uniform_request(0, 65535));   // first try hits identity, retry
      rq = uniform_request(4, 0);
      rq.counts[1] = 16'd9;
      rq.counts[2] = 16'd9;
      send_request(rq);                          // tie, lowest slot wins
      rq = uniform_request(4, 0);
      rq.counts[4] = '1;
      send_request(rq);                          // own count does not count
      send_request(uniform_request(3, 1));
      send_request(uniform_request(3, 1));
      rq = uniform_request(5, 0);
      rq.counts[6] = 16'd1;
      rq.counts[0] = 16'd2;
      send_request(rq);

      write_robots(2);
      send_request(uniform_request(1, 0));       // adopt 1,0
      send_request(uniform_request(0, 7));       // only identity left: exhausted
      send_request(uniform_request(1, 0));       // slot 0, exhausted
      send_request(uniform_request(7, 65535));   // out of range
      send_request(uniform_request(2, 3));       // first robot past the end

      write_robots(0);                           // acts as one robot
      send_request(uniform_request(0, 5));
      send_request(uniform_request(1, 5));

      write_robots(15);                          // acts as the full size
      rq = uniform_request(6, 0);
      for (int i = 0; i < IN_ROBOTS; i++) rq.counts[i] = COUNT_W'($urandom);
      send_request(rq);
      send_request(uniform_request(7, 65535));
      write_robots(1);
      send_request(uniform_request(0, 0));
   endtask

   // Random requests over a spread of settings; one phase runs without idling.
   // Small robot counts exhaust the history quickly, eight wraps the ring.
   task automatic test_random_settings();
      run_random_phase(8, 150, 1'b1);
      run_random_phase(3, 60, 1'b1);
      run_random_phase(2, 40, 1'b1);
      run_random_phase(1, 20, 1'b1);
      run_random_phase(5, 80, 1'b0);
      run_random_phase(0, 15, 1'b1);
      run_random_phase(15, 120, 1'b1);
      run_random_phase(4, 60, 1'b1);
      run_random_phase(6, 80, 1'b1);
      run_random_phase(7, 80, 1'b1);
      run_random_phase(8, 60, 1'b1);
   endtask

   // Receiver holds off for a long stretch while requests keep coming, so the
   // result register and the core fill up and req_ready drops.
   task automatic test_stalled_receiver();
      write_robots(8);
      idle_on      = 1'b0;
      hold_request = LONG_HOLD;
      repeat (10) send_request(random_request(active_robots()));
      idle_on = 1'b1;
   endtask

   // Sender stops until everything has come back, then resumes.
   task automatic test_paused_sender();
      idle_on = 1'b1;
      repeat (10) send_request(random_request(active_robots()));
      wait_drained();
      repeat (10) send_request(random_request(active_robots()));
   endtask

   // ---------------------------------------------------------------
   // Result checking
   // ---------------------------------------------------------------
   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   // Sampled at the rising edge; inputs only move on the falling edge.
   always @(posedge clock) begin : result_check
      resched_rsp_type want;
      logic [2:0]      got [OUT_SLOTS];
      if (!reset && rsp_valid && rsp_ready) begin
         ready_wait = draw_gap();
         if (expected_results.size() == 0) begin
            $error("result transfer with no request outstanding");
            error_count++;
         end else begin
            want   = expected_results.pop_front();
            got[0] = rsp_slot_0;
            got[1] = rsp_slot_1;
            got[2] = rsp_slot_2;
            got[3] = rsp_slot_3;
            got[4] = rsp_slot_4;
            got[5] = rsp_slot_5;
            got[6] = rsp_slot_6;
            got[7] = rsp_slot_7;
            check_field("status", 8'(want.status), 8'(rsp_status));
            check_field("first_replan_slot", 8'(want.first_slot), 8'(rsp_first_replan_slot));
            for (int i = 0; i < OUT_SLOTS; i++)
               check_field($sformatf("slot_%0d", i), 8'(want.slots[i]), 8'(got[i]));
         end
      end
   end

   // Receiver: per-result idle draw, plus the long hold-off counted down here.
   initial begin : result_receiver
      int hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else if (ready_wait > 0) begin
            rsp_ready <= 1'b0;
            ready_wait--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------
   // Clock, run limit
   // ---------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin : run_limit
      wait (cycle_count >= CYCLE_LIMIT);
      $display("FAILURE");
      $finish;
   end

   // ---------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------
   initial begin
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_colliding_robot = '0;
      req_collisions_0    = '0;
      req_collisions_1    = '0;
      req_collisions_2    = '0;
      req_collisions_3    = '0;
      req_collisions_4    = '0;
      req_collisions_5    = '0;
      req_collisions_6    = '0;
      req_collisions_7    = '0;
      rsp_ready           = 1'b0;
      psel                = 1'b0;
      penable             = 1'b0;
      pwrite              = 1'b0;
      paddr               = '0;
      pwdata              = '0;
      robot_setting       = ROBOTS_RESET;
      restart_schedule();

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_random_settings();
      test_stalled_receiver();
      test_paused_sender();

      // all requests in; let the last results arrive, then watch for strays
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
